[rtl/brb_pkg.sv]
// Shared types and constants of the byte ring buffer.
`default_nettype none

package brb_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int OP_W    = 1;
  localparam int BYTES_W = 64;
  localparam int CNT_W   = 4;
  localparam int FILL_W  = 7;
  localparam int CAP_W   = 7;

  // Operation codes carried in the operation field.
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_POP  = 1'b1;

  // Depth of the command queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // What the back end has to do for one accepted item.
  typedef enum logic [1:0] {
    CMD_NOTE = 2'd0,  // single result without a byte
    CMD_PUSH = 2'd1,  // write bytes, then one result
    CMD_POP  = 2'd2   // read bytes, one result per byte
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [BYTES_W-1:0]   bytes;
    logic [CNT_W-1:0]     n;       // bytes to write or read
    logic                 status;  // status of the final result
    logic [FILL_W-1:0]    fill;    // fill after a push, before a pop
  } cmd_t;

  // Control from the front end to the back end.
  typedef struct packed {
    logic              clear;  // configuration write empties the ring
    logic [CAP_W-1:0]  cap;    // slots in use
  } ctl_t;

endpackage

`default_nettype wire

[rtl/brb_in_if.sv]
// Input channel of the byte ring buffer: handshake and item fields.
`default_nettype none

interface brb_in_if;
  logic                          valid;
  logic                          ready;
  logic [brb_pkg::OP_W-1:0]      operation;
  logic [brb_pkg::BYTES_W-1:0]   push_bytes;
  logic [brb_pkg::CNT_W-1:0]     push_count;
  logic [brb_pkg::CNT_W-1:0]     pop_count;

  modport source (output valid, operation, push_bytes, push_count, pop_count,
                  input ready);
  modport sink   (input valid, operation, push_bytes, push_count, pop_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/brb_out_if.sv]
// Output channel of the byte ring buffer: handshake and result fields.
`default_nettype none

interface brb_out_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   data_byte;
  logic                         byte_valid;
  logic                         last_of_run;
  logic                         status;
  logic [brb_pkg::FILL_W-1:0]   fill_level;
  logic                         is_empty;

  modport source (output valid, data_byte, byte_valid, last_of_run, status,
                  fill_level, is_empty, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_of_run, status,
                  fill_level, is_empty, output ready);
endinterface

`default_nettype wire

[rtl/brb_front.sv]
// Front end: accepts items, tracks fill and capacity, issues commands.
`default_nettype none

module brb_front #(
  parameter int DEPTH     = 64,
  parameter int MAX_BURST = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [brb_pkg::CAP_W-1:0] cfg_wdata_i,
  brb_in_if.sink                         in_i,
  output brb_pkg::cmd_t                  cmd_o,
  output logic                           cmd_valid_o,
  input  wire logic                      cmd_ready_i,
  output brb_pkg::ctl_t                  ctl_o
);

  localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
  localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;
  localparam logic [brb_pkg::CNT_W-1:0] BURST = brb_pkg::CNT_W'(MAX_BURST);

  logic [brb_pkg::CAP_W-1:0]  cap_q, cap_d;
  logic [brb_pkg::FILL_W-1:0] count_q, count_d;
  logic [brb_pkg::FILL_W-1:0] free_room;
  logic [brb_pkg::CNT_W-1:0]  push_n, pop_n, take;
  logic                       accept, fits, shorted;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid && cmd_ready_i;

  assign push_n    = (in_i.push_count > BURST) ? BURST : in_i.push_count;
  assign pop_n     = (in_i.pop_count > BURST) ? BURST : in_i.pop_count;
  assign free_room = cap_q - count_q;
  assign fits      = {3'b000, push_n} <= free_room;
  assign shorted   = {3'b000, pop_n} > count_q;
  assign take      = shorted ? count_q[brb_pkg::CNT_W-1:0] : pop_n;

  always_comb begin
    cmd_o.bytes  = in_i.push_bytes;
    cmd_o.n      = '0;
    cmd_o.kind   = brb_pkg::CMD_NOTE;
    cmd_o.status = 1'b0;
    cmd_o.fill   = count_q;
    count_d      = count_q;
    if (in_i.operation == brb_pkg::OP_PUSH) begin
      if (!fits) begin
        cmd_o.status = 1'b1;
      end else if (push_n != '0) begin
        cmd_o.kind = brb_pkg::CMD_PUSH;
        cmd_o.n    = push_n;
        cmd_o.fill = count_q + {3'b000, push_n};
        count_d    = count_q + {3'b000, push_n};
      end
    end else begin
      cmd_o.status = shorted;
      if (take != '0) begin
        cmd_o.kind = brb_pkg::CMD_POP;
        cmd_o.n    = take;
        count_d    = count_q - {3'b000, take};
      end
    end
  end

  always_comb begin
    cap_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cap_d = brb_pkg::CAP_W'(1);
    end else if (cfg_wdata_i > brb_pkg::CAP_W'(CAP_MAX)) begin
      cap_d = brb_pkg::CAP_W'(CAP_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= brb_pkg::CAP_W'(CAP_RST);
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cap_d;
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  assign ctl_o.clear = cfg_we_i;
  assign ctl_o.cap   = cap_q;

`ifndef SYNTH
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("fill count exceeds capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0 && cap_q <= brb_pkg::CAP_W'(CAP_MAX))
    else $error("capacity out of range");

  a_refused_push_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && in_i.operation == brb_pkg::OP_PUSH && !fits
      |=> $stable(count_q))
    else $error("refused push changed the fill count");
`endif

endmodule

`default_nettype wire

[rtl/brb_cmd_queue.sv]
// Two-entry command queue between the front end and the back end.
`default_nettype none

module brb_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire brb_pkg::cmd_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output brb_pkg::cmd_t      pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);

  brb_pkg::cmd_t                slot_q [brb_pkg::QDEPTH];
  logic [brb_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [brb_pkg::QCNT_W-1:0]   cnt_q;
  logic                         do_push, do_pop;

  assign push_ready_o = cnt_q != brb_pkg::QCNT_W'(brb_pkg::QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= brb_pkg::QCNT_W'(brb_pkg::QDEPTH))
    else $error("command queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == brb_pkg::QCNT_W'(brb_pkg::QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("command queue pointers disagree with count");

  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == brb_pkg::QCNT_W'(brb_pkg::QDEPTH) |-> !do_push)
    else $error("command queue written while full");
`endif

endmodule

`default_nettype wire

[rtl/brb_back.sv]
// Back end: byte memory, ring positions and the result register.
`default_nettype none

module brb_back #(
  parameter int DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire brb_pkg::ctl_t ctl_i,
  input  wire brb_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  brb_out_if.source          out_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = ((PTR_W > brb_pkg::CAP_W) ? PTR_W : brb_pkg::CAP_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [7:0]                   mem_q [DEPTH];
  logic [7:0]                   rdata_q;
  logic [1:0]                   state_q, state_d;
  logic [PTR_W-1:0]             wr_pos_q, wr_pos_d, rd_pos_q, rd_pos_d;
  logic [brb_pkg::BYTES_W-1:0]  bytes_q, bytes_d;
  logic [2:0]                   idx_q, idx_d;
  logic [brb_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [brb_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic                         status_q, status_d;
  logic                         mem_we, mem_re;
  logic [7:0]                   mem_wdata;
  logic                         out_free, out_load, pop_last;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q, out_byte_d;
  logic                         out_bvalid_q, out_bvalid_d;
  logic                         out_last_q, out_last_d;
  logic                         out_status_q, out_status_d;
  logic [brb_pkg::FILL_W-1:0]   out_fill_q, out_fill_d;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos,
                                                input logic [brb_pkg::CAP_W-1:0] cap);
    logic [CMP_W-1:0] nxt;
    nxt = CMP_W'(pos) + CMP_W'(1);
    return (nxt >= CMP_W'(cap)) ? '0 : nxt[PTR_W-1:0];
  endfunction

  assign out_free  = !out_valid_q || out_o.ready;
  assign pop_last  = cnt_q == brb_pkg::CNT_W'(1);
  assign mem_wdata = bytes_q[{idx_q, 3'b000} +: 8];

  always_comb begin
    state_d      = state_q;
    wr_pos_d     = wr_pos_q;
    rd_pos_d     = rd_pos_q;
    bytes_d      = bytes_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    status_d     = status_q;
    cmd_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    out_byte_d   = '0;
    out_bvalid_d = 1'b0;
    out_last_d   = 1'b1;
    out_status_d = 1'b0;
    out_fill_d   = fill_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            brb_pkg::CMD_NOTE: begin
              if (out_free) begin
                cmd_ready_o  = 1'b1;
                out_load     = 1'b1;
                out_status_d = cmd_i.status;
                out_fill_d   = cmd_i.fill;
              end
            end
            brb_pkg::CMD_PUSH: begin
              cmd_ready_o = 1'b1;
              bytes_d     = cmd_i.bytes;
              idx_d       = '0;
              cnt_d       = cmd_i.n;
              fill_d      = cmd_i.fill;
              state_d     = S_PUSH;
            end
            brb_pkg::CMD_POP: begin
              cmd_ready_o = 1'b1;
              mem_re      = 1'b1;
              rd_pos_d    = next_pos(rd_pos_q, ctl_i.cap);
              cnt_d       = cmd_i.n;
              fill_d      = cmd_i.fill;
              status_d    = cmd_i.status;
              state_d     = S_POP;
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end
      S_PUSH: begin
        mem_we   = 1'b1;
        wr_pos_d = next_pos(wr_pos_q, ctl_i.cap);
        idx_d    = idx_q + 3'd1;
        cnt_d    = cnt_q - brb_pkg::CNT_W'(1);
        if (cnt_q == brb_pkg::CNT_W'(1)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_d   = rdata_q;
          out_bvalid_d = 1'b1;
          out_last_d   = pop_last;
          out_status_d = pop_last ? status_q : 1'b0;
          out_fill_d   = fill_q - brb_pkg::FILL_W'(1);
          fill_d       = fill_q - brb_pkg::FILL_W'(1);
          cnt_d        = cnt_q - brb_pkg::CNT_W'(1);
          if (pop_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re   = 1'b1;
            rd_pos_d = next_pos(rd_pos_q, ctl_i.cap);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_pos_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    fill_q   <= fill_d;
    status_q <= status_d;
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      out_bvalid_q <= out_bvalid_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_fill_q   <= out_fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_i.clear) begin
        wr_pos_q <= '0;
        rd_pos_q <= '0;
      end else begin
        wr_pos_q <= wr_pos_d;
        rd_pos_q <= rd_pos_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_byte   = out_byte_q;
  assign out_o.byte_valid  = out_bvalid_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.status      = out_status_q;
  assign out_o.fill_level  = out_fill_q;
  assign out_o.is_empty    = out_fill_q == '0;

`ifndef SYNTH
  a_no_read_write_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory written and read in the same cycle");

  a_busy_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH || state_q == S_POP) |-> cnt_q != '0)
    else $error("back end busy with no bytes left");

  a_pop_byte_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_bvalid_d |-> state_q == S_POP)
    else $error("byte result loaded outside a pop");
`endif

endmodule

`default_nettype wire

[rtl/byte_ring_buffer.sv]
// Top level of the byte ring buffer: front end, command queue and back end.
`default_nettype none

// A circular byte FIFO whose ring length is set by capacity_in_use (1 up to
// min(DEPTH, 127); a write of 0 counts as 1 and a larger value as that bound).
// Writing the register empties the ring, and it must only be written while
// the block is idle. A push transfer carries up to MAX_BURST bytes and is
// taken whole or refused whole; either way it produces one result whose
// status flags a refusal. A pop transfer produces one result per byte removed,
// oldest first, with last_of_run on the final one and status set there if
// fewer bytes were stored than requested; a pop that removes nothing gives a
// single result without a byte. The front end decides every outcome at the
// input transfer and queues a command, so a new input is taken while the back
// end is still busy, up to two commands ahead. The back end owns the byte
// memory, which has one port used for either a write or a read in each cycle.
// A push of n bytes therefore keeps the back end busy taking the command,
// writing its n bytes and issuing one result. A pop of n bytes reads memory
// as it takes the command and then delivers a byte in every cycle the output
// side takes it. An item with no memory access (refused push, empty push or
// empty pop) is taken in the same cycle as its result is loaded.
// The output is a register, so a stalled result never stops the front end
// from taking the next input while the queue has room.
module byte_ring_buffer #(
  parameter int DEPTH     = 64,
  parameter int MAX_BURST = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [brb_pkg::CAP_W-1:0] cfg_wdata_i,
  brb_in_if.sink                         in_i,
  brb_out_if.source                      out_o
);

  // Command from the front end into the queue.
  brb_pkg::cmd_t front_cmd;
  logic          front_valid;
  logic          front_ready;

  // Command from the queue into the back end.
  brb_pkg::cmd_t back_cmd;
  logic          back_valid;
  logic          back_ready;

  // Capacity and ring clear, owned by the front end.
  brb_pkg::ctl_t ctl;

  brb_front #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .ctl_o       (ctl)
  );

  brb_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
